>>> rtl/u8c_pkg.sv
// Shared types and constants for the tick-driven UART with command decode.
package u8c_pkg;

    // Bit period register and the counters that run against it.
    localparam int PERIOD_W = 12;
    localparam int CNT_W    = 13;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 12'd104;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 12'd2;

    // Register map: index of each configuration register.
    localparam logic REG_BIT_PERIOD = 1'b0;

    // Received bytes that act as mode commands.
    localparam logic [7:0] CMD_MODE_FIRST = 8'hC1;
    localparam logic [7:0] CMD_MODE_LAST  = 8'hC4;

    // Mode codes.
    localparam logic [1:0] MODE_FIVE_PER_SEC = 2'd0;
    localparam logic [1:0] MODE_ONCE_PER_SEC = 2'd1;
    localparam logic [1:0] MODE_HALTED       = 2'd2;
    localparam logic [1:0] MODE_TRANSMIT     = 2'd3;

    // Transmitter view of one tick.
    typedef struct packed {
        logic line;
        logic busy;
        logic accepted;
    } tx_res_t;

    // Receiver view of one tick.
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] rx_data;
        logic [1:0] mode;
        logic       mode_updated;
    } rx_res_t;

endpackage

>>> rtl/u8c_tx.sv
// Transmitter: frames one byte as start bit, data bits LSB first and stop bit.
module u8c_tx #(
    parameter int DATA_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [u8c_pkg::PERIOD_W-1:0]  period,
    input  logic                          send_valid,
    input  logic [7:0]                    send_byte,
    output u8c_pkg::tx_res_t              res
);

    localparam int IDX_W = $clog2(DATA_BITS + 2);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DATA_BITS + 1);
    localparam logic [IDX_W-1:0] IDX_DATA_END = IDX_W'(DATA_BITS);

    logic [7:0]                 shift_reg, shift_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [u8c_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       active_reg, active_next;
    logic                       accepted;
    logic [u8c_pkg::CNT_W-1:0]  cnt_inc;
    logic [IDX_W-1:0]           data_pos;
    logic                       line;

    // Advance the frame by one tick, or start a frame when idle.
    always_comb
    begin
        shift_next  = shift_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        accepted    = 1'b0;
        cnt_inc     = cnt_reg + u8c_pkg::CNT_W'(1);
        if (active_reg)
        begin
            cnt_next = cnt_inc;
            if (cnt_inc >= u8c_pkg::CNT_W'(period))
            begin
                cnt_next = '0;
                if (idx_reg == IDX_LAST)
                begin
                    active_next = 1'b0;
                    idx_next    = '0;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
        end
        else if (send_valid)
        begin
            active_next = 1'b1;
            shift_next  = send_byte;
            idx_next    = '0;
            cnt_next    = '0;
            accepted    = 1'b1;
        end
    end

    // Line level after this tick; data bits beyond the eighth go out as zero.
    always_comb
    begin
        data_pos = idx_next - IDX_W'(1);
        if (!active_next)
        begin
            line = 1'b1;
        end
        else if (idx_next == '0)
        begin
            line = 1'b0;
        end
        else if (idx_next <= IDX_DATA_END)
        begin
            line = ((IDX_W + 1)'(data_pos) < (IDX_W + 1)'(8)) ? shift_next[data_pos[2:0]] : 1'b0;
        end
        else
        begin
            line = 1'b1;
        end
    end

    assign res.line     = line;
    assign res.busy     = active_next;
    assign res.accepted = accepted;

    // Frame state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= '0;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (step)
        begin
            shift_reg  <= shift_next;
            idx_reg    <= idx_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
        end
    end

endmodule

>>> rtl/u8c_rx.sv
// Receiver: arms on a falling edge, samples data bits and decodes mode commands.
module u8c_rx #(
    parameter int DATA_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [u8c_pkg::PERIOD_W-1:0]  period,
    input  logic                          rx_line,
    output u8c_pkg::rx_res_t              res
);

    localparam int IDX_W = $clog2(DATA_BITS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DATA_BITS - 1);

    logic                       active_reg, active_next;
    logic [u8c_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [7:0]                 shift_reg, shift_next;
    logic                       prev_reg;
    logic [7:0]                 last_reg, last_next;
    logic [1:0]                 mode_reg, mode_next;
    logic                       got;
    logic                       updated;
    logic [u8c_pkg::CNT_W-1:0]  cnt_inc;
    logic [u8c_pkg::CNT_W-1:0]  target;
    logic [7:0]                 mode_diff;

    // First sample lies one and a half periods after the falling edge.
    assign target = (idx_reg == '0)
                  ? u8c_pkg::CNT_W'(period) + u8c_pkg::CNT_W'(period >> 1)
                  : u8c_pkg::CNT_W'(period);

    // Count ticks, sample bits, and latch the byte and any command on the last bit.
    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        shift_next  = shift_reg;
        last_next   = last_reg;
        mode_next   = mode_reg;
        got         = 1'b0;
        updated     = 1'b0;
        cnt_inc     = cnt_reg + u8c_pkg::CNT_W'(1);
        mode_diff   = '0;
        if (active_reg)
        begin
            cnt_next = cnt_inc;
            if (cnt_inc >= target)
            begin
                cnt_next = '0;
                if (((IDX_W + 1)'(idx_reg) < (IDX_W + 1)'(8)) && rx_line)
                begin
                    shift_next[idx_reg[2:0]] = 1'b1;
                end
                if (idx_reg == IDX_LAST)
                begin
                    active_next = 1'b0;
                    idx_next    = '0;
                    last_next   = shift_next;
                    got         = 1'b1;
                    if ((shift_next >= u8c_pkg::CMD_MODE_FIRST) &&
                        (shift_next <= u8c_pkg::CMD_MODE_LAST))
                    begin
                        mode_diff = shift_next - u8c_pkg::CMD_MODE_FIRST;
                        mode_next = mode_diff[1:0];
                        updated   = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
        end
        else if (prev_reg && !rx_line)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            idx_next    = '0;
            shift_next  = '0;
        end
    end

    assign res.byte_valid   = got;
    assign res.rx_data      = last_next;
    assign res.mode         = mode_next;
    assign res.mode_updated = updated;

    // Receiver and mode state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            shift_reg  <= '0;
            prev_reg   <= 1'b1;
            last_reg   <= '0;
            mode_reg   <= u8c_pkg::MODE_HALTED;
        end
        else if (step)
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            shift_reg  <= shift_next;
            prev_reg   <= rx_line;
            last_reg   <= last_next;
            mode_reg   <= mode_next;
        end
    end

endmodule

>>> rtl/uart_8n1_with_command_decode.sv
// Top level: tick-driven 8N1 UART with receive command decode and APB register.
//
// Each input beat is one tick of the serial line: the sampled rx_line plus an
// optional send request (send_valid, send_byte). Each accepted input beat gives
// exactly one output beat with the transmit line level, busy flag, whether the
// request started a frame, any completed received byte and the command mode.
// The transmitter and receiver both advance on the accepted beat; the result
// is captured in an output register. Throughput is one beat per cycle while
// the output is not stalled: in_ready is high whenever the output register
// is empty or is being emptied in the same cycle, so the only limit is the
// single output register. When the receiver of the output stalls, in_ready
// drops, the held beat stays put and no tick is lost.
// The APB register at address 0 holds bit_period_ticks (ticks per bit, values
// below 2 act as 2); write it only while the block is idle.
// Reset (rst_n low) empties the output register, stops both directions, sets
// the line history to idle high, the mode to stop and the period to 104.
module uart_8n1_with_command_decode #(
    parameter int DATA_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Tick input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        rx_line,
    input  logic        send_valid,
    input  logic [7:0]  send_byte,
    // Result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tx_line,
    output logic        tx_busy,
    output logic        send_accepted,
    output logic        rx_byte_valid,
    output logic [7:0]  rx_byte,
    output logic [1:0]  mode,
    output logic        mode_updated,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [u8c_pkg::PERIOD_W-1:0] period_reg;
    logic [u8c_pkg::PERIOD_W-1:0] period_eff;
    logic                         accept;
    logic                         out_valid_reg;
    u8c_pkg::tx_res_t             tx_res;
    u8c_pkg::rx_res_t             rx_res;
    u8c_pkg::tx_res_t             tx_res_reg;
    u8c_pkg::rx_res_t             rx_res_reg;

    // Register access.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == u8c_pkg::REG_BIT_PERIOD)
                  ? 32'(period_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= u8c_pkg::PERIOD_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr[2] == u8c_pkg::REG_BIT_PERIOD))
        begin
            period_reg <= pwdata[u8c_pkg::PERIOD_W-1:0];
        end
    end

    // Very short periods behave as the minimum.
    assign period_eff = (period_reg < u8c_pkg::PERIOD_MIN) ? u8c_pkg::PERIOD_MIN : period_reg;

    // Handshake: a tick is taken whenever the output register can take its result.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    u8c_tx #(
        .DATA_BITS (DATA_BITS)
    ) u_tx (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .period     (period_eff),
        .send_valid (send_valid),
        .send_byte  (send_byte),
        .res        (tx_res)
    );

    u8c_rx #(
        .DATA_BITS (DATA_BITS)
    ) u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .period  (period_eff),
        .rx_line (rx_line),
        .res     (rx_res)
    );

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tx_res_reg <= tx_res;
            rx_res_reg <= rx_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_line       = tx_res_reg.line;
    assign tx_busy       = tx_res_reg.busy;
    assign send_accepted = tx_res_reg.accepted;
    assign rx_byte_valid = rx_res_reg.byte_valid;
    assign rx_byte       = rx_res_reg.rx_data;
    assign mode          = rx_res_reg.mode;
    assign mode_updated  = rx_res_reg.mode_updated;

    // A frame that has just started is busy and drives the start bit.
    a_start_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && tx_res_reg.accepted |-> tx_res_reg.busy && !tx_res_reg.line)
        else $error("accepted send does not show start bit");

    // A mode update only comes with a completed byte.
    a_mode_with_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rx_res_reg.mode_updated |-> rx_res_reg.byte_valid)
        else $error("mode update without received byte");

    // The decoded mode matches the command byte just received.
    a_mode_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rx_res_reg.mode_updated |->
            rx_res_reg.mode == (rx_res_reg.rx_data[1:0] - 2'd1))
        else $error("mode does not match command byte");

    // An empty output register never holds off the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output register");

endmodule
